/* sv/lsq_pkg.sv */
// Shared types and constants for the largest all-ones square block.
// No dependencies; imported by every module of the block.
package lsq_pkg;

   localparam int MAX_DIM = 128;
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int SIDE_W = $clog2(MAX_DIM + 1);
   localparam int POS_W = SIDE_W + 1;
   localparam int AREA_W = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int CFG_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register select: paddr[2] picks the word.
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic              raised;
      logic              first_row;
      logic              first_col;
      logic              last_grid;
      logic [IDX_W-1:0]  slot;
   } lsq_item_type;

endpackage

/* sv/largest_ones_square.sv */
// Largest all-ones square: a grid's last cell passes the queue, memory read,
// recurrence and square registers before rsp_valid rises. Throughput one cell
// per cycle unless a stalled result holds a grid's last cell; the previous-row
// memory reads one slot and writes one slot per cycle. Reset is synchronous,
// active high: it clears the position, best side, queue and result, and sets
// both counts to one. The previous-row memory is not cleared; the first row ignores it.
module largest_ones_square (
   input  logic                             clock,
   input  logic                             reset,
   // cell input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cell_req,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lsq_pkg::AREA_W-1:0]       rsp_best_area,
   output logic [lsq_pkg::SIDE_W-1:0]       rsp_best_edge,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lsq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lsq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import lsq_pkg::*;

   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [CFG_W-1:0] col_count_ff, col_count_in;
   logic             csr_write;
   logic             push, pop, queue_full, queue_empty;
   lsq_item_type     push_item, head_item;

   // Register port: zero wait states, the access phase completes the transfer.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_ROW_COUNT: row_count_in = csr_pwdata[CFG_W-1:0];
            CSR_COL_COUNT: col_count_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the raw stored value, not the clamped one.
   always_comb begin
      unique case (csr_paddr[2])
         CSR_ROW_COUNT: csr_prdata = CSR_DATA_W'(row_count_ff);
         CSR_COL_COUNT: csr_prdata = CSR_DATA_W'(col_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_W'(1);
         col_count_ff <= CFG_W'(1);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Front end: take a cell whenever the queue has room and tag its position.
   lsq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cell_req (req_cell_req),
      .row_count    (row_count_ff),
      .col_count    (col_count_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item)
   );

   // Queue: lets the front keep taking cells while a result waits downstream.
   lsq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   // Back end: previous-row lookup, recurrence, best side, result transfer.
   lsq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_best_area (rsp_best_area),
      .rsp_best_edge (rsp_best_edge)
   );

endmodule

/* sv/lsq_front.sv */
// Front end: accepts cells, tracks the grid position and tags each cell.
// Depends on lsq_pkg.
module lsq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cell_req,
   input  logic [lsq_pkg::CFG_W-1:0]   row_count,
   input  logic [lsq_pkg::CFG_W-1:0]   col_count,
   input  logic                        queue_full,
   output logic                        push,
   output lsq_pkg::lsq_item_type       push_item
);
   import lsq_pkg::*;

   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [SIDE_W-1:0] rows_eff, cols_eff;
   logic              last_col, last_row;

   // Treat zero as one, clamp above the grid limit.
   always_comb begin
      if (row_count == '0) begin
         rows_eff = SIDE_W'(1);
      end else if (32'(row_count) > 32'(MAX_DIM)) begin
         rows_eff = SIDE_W'(MAX_DIM);
      end else begin
         rows_eff = SIDE_W'(row_count);
      end
      if (col_count == '0) begin
         cols_eff = SIDE_W'(1);
      end else if (32'(col_count) > 32'(MAX_DIM)) begin
         cols_eff = SIDE_W'(MAX_DIM);
      end else begin
         cols_eff = SIDE_W'(col_count);
      end
   end

   assign last_col = (POS_W'(col_ff) + POS_W'(1)) >= POS_W'(cols_eff);
   assign last_row = (POS_W'(row_ff) + POS_W'(1)) >= POS_W'(rows_eff);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.raised    = req_cell_req;
      push_item.first_row = (row_ff == '0);
      push_item.first_col = (col_ff == '0);
      push_item.last_grid = last_col && last_row;
      push_item.slot      = col_ff;
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* sv/lsq_queue.sv */
// Short FIFO of tagged cells between the front and back ends.
// Depends on lsq_pkg.
module lsq_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lsq_pkg::lsq_item_type  push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output lsq_pkg::lsq_item_type  head_item
);
   import lsq_pkg::*;

   lsq_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/lsq_back.sv */
// Back end: previous-row memory, min-of-three recurrence, best tracking and
// the result register. Depends on lsq_pkg.
module lsq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  lsq_pkg::lsq_item_type         head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsq_pkg::AREA_W-1:0]    rsp_best_area,
   output logic [lsq_pkg::SIDE_W-1:0]    rsp_best_edge
);
   import lsq_pkg::*;

   logic [SIDE_W-1:0] side_mem [MAX_DIM];
   logic [SIDE_W-1:0] up_rd_ff;

   logic              s1_valid_ff, s1_valid_in;
   lsq_item_type      s1_item_ff;
   logic              s1_byp_ff;
   logic [SIDE_W-1:0] s1_byp_side_ff;

   logic [SIDE_W-1:0] left_ff, diag_ff, best_ff, best_in;

   logic              s3_valid_ff, s3_valid_in;
   logic [SIDE_W-1:0] s3_edge_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0] rsp_area_ff;
   logic [SIDE_W-1:0] rsp_edge_ff;

   logic              out_free, s3_free, s2_fire, s1_free;
   logic [SIDE_W-1:0] up, left, diag, m1, m2, side, best_next;
   logic [SIDE_W:0]   sum;

   // Handshake chain, back to front.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_fire  = s1_valid_ff && (!s1_item_ff.last_grid || s3_free);
   assign s1_free  = !s1_valid_ff || s2_fire;
   assign pop      = !queue_empty && s1_free;

   // Recurrence on the cell held in stage one.
   always_comb begin
      up   = s1_item_ff.first_row ? '0 : (s1_byp_ff ? s1_byp_side_ff : up_rd_ff);
      left = s1_item_ff.first_col ? '0 : left_ff;
      diag = (s1_item_ff.first_row || s1_item_ff.first_col) ? '0 : diag_ff;
      m1   = (up < left) ? up : left;
      m2   = (m1 < diag) ? m1 : diag;
      sum  = {1'b0, m2} + (SIDE_W+1)'(1);
      if (!s1_item_ff.raised) begin
         side = '0;
      end else if (32'(sum) > MAX_DIM) begin
         side = SIDE_W'(MAX_DIM);
      end else begin
         side = sum[SIDE_W-1:0];
      end
      best_next = (side > best_ff) ? side : best_ff;
   end

   always_comb begin
      best_in = best_ff;
      if (s2_fire) begin
         best_in = s1_item_ff.last_grid ? '0 : best_next;
      end
   end

   assign s1_valid_in  = pop ? 1'b1 : (s2_fire ? 1'b0 : s1_valid_ff);
   assign s3_valid_in  = (s2_fire && s1_item_ff.last_grid) ? 1'b1
                       : (out_free ? 1'b0 : s3_valid_ff);
   assign rsp_valid_in = (s3_valid_ff && out_free) ? 1'b1
                       : (!rsp_stall ? 1'b0 : rsp_valid_ff);

   // Previous-row sides: read on pop, write on fire.
   always_ff @(posedge clock) begin
      if (pop) begin
         up_rd_ff <= side_mem[head_item.slot];
      end
      if (s2_fire) begin
         side_mem[s1_item_ff.slot] <= side;
      end
   end

   // Payload registers. Catch a same-cycle write to the slot being read.
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_item_ff     <= head_item;
         s1_byp_ff      <= s2_fire && (s1_item_ff.slot == head_item.slot);
         s1_byp_side_ff <= side;
      end
      if (s2_fire) begin
         left_ff <= side;
         diag_ff <= up;
      end
      if (s2_fire && s1_item_ff.last_grid) begin
         s3_edge_ff <= best_next;
      end
      if (s3_valid_ff && out_free) begin
         rsp_edge_ff <= s3_edge_ff;
         rsp_area_ff <= AREA_W'(s3_edge_ff * s3_edge_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         best_ff      <= best_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_area = rsp_area_ff;
   assign rsp_best_edge = rsp_edge_ff;

   a_area_matches_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_area_ff == AREA_W'(rsp_edge_ff * rsp_edge_ff)))
      else $error("result area does not match edge");

   a_edge_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_edge_ff) <= MAX_DIM))
      else $error("result edge beyond grid limit");

   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s1_item_ff.last_grid) |=> (best_ff == '0))
      else $error("best side not cleared after grid end");

   a_no_fire_empty: assert property (@(posedge clock) disable iff (reset)
      s2_fire |-> s1_valid_ff && (32'(best_next) <= MAX_DIM))
      else $error("recurrence fired without a cell or out of range");

endmodule

/* tb/tb_largest_ones_square.sv */
// Self-checking testbench for largest_ones_square: streams binary grids, predicts the
// largest all-ones square of each grid and checks every result transfer against it.
// Depends on lsq_pkg and the largest_ones_square RTL.
module tb_largest_ones_square;
   timeunit 1ns;
   timeprecision 1ps;

   import lsq_pkg::*;

   // Slowest correct run is about 1.2k cells, a stalled result per cell at worst,
   // plus register writes and drains; allow far more.
   localparam int CYCLE_LIMIT  = 600000;
   // Clocks waited after every pending square has come back, as a margin.
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_CELLS = 550;

   typedef struct {
      logic [AREA_W-1:0] area;
      logic [SIDE_W-1:0] side;
   } square_type;

   // DUT inputs start known; the driver, monitor and register task take over later.
   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_cell_req = 1'b0;
   logic                  rsp_stall    = 1'b0;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [AREA_W-1:0]     rsp_best_area;
   logic [SIDE_W-1:0]     rsp_best_edge;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Cells waiting to be driven, and squares waiting to come out.
   logic                  cell_q [$];
   square_type            square_q [$];

   // Predictor copy of the block's registers and state.
   logic [CFG_W-1:0]      row_cfg;
   logic [CFG_W-1:0]      col_cfg;
   logic [SIDE_W-1:0]     above_sides [MAX_DIM];
   logic [SIDE_W-1:0]     left_len;
   logic [SIDE_W-1:0]     diag_len;
   logic [SIDE_W-1:0]     best_len;
   int unsigned           row_pos;
   int unsigned           col_pos;

   // Handshake flags captured at the rising edge, used by the falling-edge drivers.
   bit                    cell_xfer;
   bit                    rsp_xfer;
   bit                    sender_idle;
   bit                    receiver_idle;
   int                    gap_left;
   int                    stall_left;
   int                    error_count;
   int                    cycle_count;

   largest_ones_square uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cell_req  (req_cell_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_best_area (rsp_best_area),
      .rsp_best_edge (rsp_best_edge),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      error_count++;
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
   endtask

   // A count of zero means one; counts above the array size saturate.
   function automatic int unsigned clamp_count(logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
   endfunction

   // Advance the predictor by one accepted cell; queue a square at the end of a grid.
   function automatic void predict_cell(logic raised);
      int unsigned rows;
      int unsigned cols;
      int unsigned slot;
      int unsigned up;
      int unsigned lft;
      int unsigned dg;
      int unsigned len;
      square_type  res;
      rows = clamp_count(row_cfg);
      cols = clamp_count(col_cfg);
      slot = (col_pos < MAX_DIM) ? col_pos : MAX_DIM - 1;
      up   = (row_pos == 0) ? 0 : above_sides[slot];
      lft  = (col_pos == 0) ? 0 : left_len;
      dg   = (row_pos == 0 || col_pos == 0) ? 0 : diag_len;
      len  = 0;
      if (raised) begin
         // Corner side is one more than the least of its three neighbors.
         len = up;
         if (lft < len) len = lft;
         if (dg < len) len = dg;
         len++;
         if (len > MAX_DIM) len = MAX_DIM;
      end
      diag_len = SIDE_W'(up);
      left_len = SIDE_W'(len);
      above_sides[slot] = SIDE_W'(len);
      if (len > best_len) best_len = SIDE_W'(len);
      if (col_pos + 1 >= cols) begin
         col_pos  = 0;
         left_len = 0;
         diag_len = 0;
         if (row_pos + 1 >= rows) begin
            res.area = AREA_W'(best_len) * AREA_W'(best_len);
            res.side = best_len;
            square_q.push_back(res);
            row_pos  = 0;
            best_len = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endfunction

   // Sample both channels at the rising edge: predict on a cell transfer, check a result.
   always @(posedge clock) begin : capture
      square_type want;
      if (reset) begin
         cell_xfer = 1'b0;
         rsp_xfer  = 1'b0;
      end else begin
         cell_xfer = req_valid && !req_stall;
         rsp_xfer  = rsp_valid && !rsp_stall;
         if (cell_xfer) predict_cell(req_cell_req);
         if (rsp_xfer) begin
            if (square_q.size() == 0) begin
               report_mismatch("result with nothing pending, area", rsp_best_area, 0);
            end else begin
               want = square_q.pop_front();
               if (rsp_best_area !== want.area)
                  report_mismatch("best_area", rsp_best_area, want.area);
               if (rsp_best_edge !== want.side)
                  report_mismatch("best_edge", rsp_best_edge, want.side);
            end
         end
      end
   end

   // Cell driver: hold a stalled cell, otherwise wait out the drawn gap and present the next.
   always @(negedge clock) begin : drive_cells
      if (reset) begin
         req_valid    <= 1'b0;
         req_cell_req <= 1'b0;
         gap_left      = 0;
      end else if (!req_valid || cell_xfer) begin
         if (gap_left != 0 || cell_q.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_valid    <= 1'b0;
            req_cell_req <= 1'($urandom_range(0, 1));
         end else begin
            req_valid    <= 1'b1;
            req_cell_req <= cell_q.pop_front();
            gap_left      = sender_idle ? $urandom_range(0, 5) : 0;
         end
      end
   end

   // Result receiver: after each result transfer, stall for a drawn number of cycles.
   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_xfer) stall_left = receiver_idle ? $urandom_range(0, 5) : 0;
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_largest_ones_square: done, errors");
         $finish;
      end
   end

   // Register write: setup cycle, then access cycle until pready; mirror into the predictor.
   task automatic csr_write(logic sel, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == CSR_ROW_COUNT) row_cfg = data[CFG_W-1:0];
      else col_cfg = data[CFG_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Block until every queued cell has gone out and every square has come back.
   task automatic wait_drained();
      while (cell_q.size() != 0 || req_valid || square_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Queue cells from a pattern, most significant bit first.
   task automatic push_bits(logic [31:0] pattern, int count);
      for (int i = count - 1; i >= 0; i--) cell_q.push_back(pattern[i]);
   endtask

   // Queue one whole grid; thresh/16 is the chance of a raised cell.
   task automatic push_grid(int rows, int cols, int thresh);
      for (int i = 0; i < rows * cols; i++) cell_q.push_back($urandom_range(0, 15) < thresh);
   endtask

   initial begin : stimulus
      int rows;
      int cols;
      int grids;
      int random_cells;
      int density [4];
      density       = '{8, 12, 15, 16};
      random_cells  = 0;
      error_count   = 0;
      cycle_count   = 0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      // Mirror the block's reset state.
      row_cfg  = CFG_W'(1);
      col_cfg  = CFG_W'(1);
      left_len = 0;
      diag_len = 0;
      best_len = 0;
      row_pos  = 0;
      col_pos  = 0;
      foreach (above_sides[i]) above_sides[i] = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: default 1x1 grid, a sunken then a raised cell.
      push_bits(32'b01, 2);
      wait_drained();
      // 2x2 full square, then a 2x2 with one hole.
      csr_write(CSR_ROW_COUNT, 32'd2);
      csr_write(CSR_COL_COUNT, 32'd2);
      push_bits(32'b1111_1101, 8);
      wait_drained();
      // Zero counts fall back to one; upper data bits must be ignored.
      csr_write(CSR_ROW_COUNT, 32'hFFFF_FF00);
      csr_write(CSR_COL_COUNT, 32'hA5A5_A500);
      push_bits(32'b1, 1);
      wait_drained();
      // 3x3 with two opposite corners sunken: side two.
      csr_write(CSR_ROW_COUNT, 32'd3);
      csr_write(CSR_COL_COUNT, 32'd3);
      push_bits(32'b110_111_011, 9);
      wait_drained();
      // Single row: no square larger than one.
      csr_write(CSR_ROW_COUNT, 32'd1);
      csr_write(CSR_COL_COUNT, 32'd5);
      push_bits(32'b01101, 5);
      wait_drained();

      // Extremes: a count above the limit saturates; tall column and wide row.
      csr_write(CSR_ROW_COUNT, 32'd255);
      csr_write(CSR_COL_COUNT, 32'd0);
      push_grid(MAX_DIM, 1, 12);
      wait_drained();
      csr_write(CSR_ROW_COUNT, 32'd1);
      csr_write(CSR_COL_COUNT, MAX_DIM);
      push_grid(1, MAX_DIM, 12);
      wait_drained();
      // A 16x16 grid of ones, run without idling to push cells back to back.
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      csr_write(CSR_ROW_COUNT, 32'd16);
      csr_write(CSR_COL_COUNT, 32'd16);
      push_grid(16, 16, 16);
      wait_drained();

      // Random phases: small grids mostly, a few larger, varied density and idling.
      while (random_cells < RANDOM_CELLS) begin
         rows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         cols = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         // A one-count is sometimes written as zero; upper data bits are random.
         csr_write(CSR_ROW_COUNT, ($urandom() << 8) |
                   ((rows == 1 && $urandom_range(0, 1)) ? 0 : rows));
         csr_write(CSR_COL_COUNT, ($urandom() << 8) |
                   ((cols == 1 && $urandom_range(0, 1)) ? 0 : cols));
         grids = $urandom_range(1, 4);
         for (int g = 0; g < grids && random_cells < RANDOM_CELLS; g++) begin
            push_grid(rows, cols, density[$urandom_range(0, 3)]);
            random_cells += rows * cols;
            // Now and then hold the sender until every pending square is back.
            if ($urandom_range(0, 3) == 0) wait_drained();
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("tb_largest_ones_square: done, clean");
      end else begin
         $display("tb_largest_ones_square: done, errors");
      end
      $finish;
   end

endmodule
